// ===== hw/rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps

package bpa_pkg;

  // fixed field widths
  localparam int unsigned PAGE_W    = 40;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // parameter defaults
  localparam int unsigned MAX_PAGES_DEF = 65536;
  localparam int unsigned WORD_BITS_DEF = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 17'h10000;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_RANGE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FETCH,
    ST_MODIFY,
    ST_SCAN,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    clear_step;
    logic    capture;
    logic    scan_start;
    logic    scan_step;
    logic    div_mul;
    logic    div_rem;
    logic    modify;
    logic    res_we;
    status_e res_status;
    logic    load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic in_range;
    logic scan_hit;
    logic scan_miss;
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/bpa_ram.sv =====
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/bpa_ctrl.sv =====
`timescale 1ns / 1ps

module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t cmd_o
);

  import bpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.res_status  = STS_OK;
    in_stall_o        = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (sts_i.op)
          OP_ALLOC: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
          OP_FREE, OP_MARK: begin
            if (sts_i.in_range) begin
              state_d = ST_DIV;
            end else begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = STS_RANGE;
              state_d          = ST_DONE;
            end
          end
          default: begin
            // no-op code answers ok
            cmd_o.res_we = 1'b1;
            state_d      = ST_DONE;
          end
        endcase
      end
      ST_DIV: begin
        cmd_o.div_mul = 1'b1;
        state_d       = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.div_rem = 1'b1;
        state_d       = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd_o.modify = 1'b1;
        cmd_o.res_we = 1'b1;
        state_d      = ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit || sts_i.scan_miss) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bpa_dpath.sv =====
`timescale 1ns / 1ps

module bpa_dpath #(
  parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bpa_pkg::PAGE_W-1:0]       cfg_data_i,
  input  logic [bpa_pkg::OP_W-1:0]         opcode_i,
  input  logic [bpa_pkg::PAGE_W-1:0]       page_number_i,
  input  bpa_pkg::cmd_t                    cmd_i,
  output bpa_pkg::sts_t                    sts_o,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [bpa_pkg::PAGE_W-1:0]       result_page_o,
  output logic [bpa_pkg::STATUS_W-1:0]     status_o
);

  import bpa_pkg::*;

  localparam int unsigned MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned IDX_W     = CNT_W;
  localparam int unsigned FIRST_W   = CNT_W + 1;
  // reciprocal multiply, exact for every index below 2^IDX_W
  localparam int unsigned DIV_SHIFT = IDX_W + 2 * BIT_W;
  localparam int unsigned PROD_W    = IDX_W + DIV_SHIFT;
  localparam longint unsigned DIV_MUL =
    ((64'd1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;

  // configuration
  logic [PAGE_W-1:0] base_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  live_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= PAGE_COUNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_BASE_PAGE) begin
        base_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_PAGE_COUNT) begin
        count_q <= cfg_data_i[CNT_W-1:0];
      end
    end
  end

  assign live_cnt = (64'(MAX_PAGES) < 64'(count_q)) ? CNT_W'(MAX_PAGES) : count_q;

  // captured item
  op_e               op_q;
  logic [PAGE_W-1:0] page_q;
  logic [PAGE_W-1:0] diff;
  logic              in_range;
  logic [IDX_W-1:0]  idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(opcode_i);
      page_q <= page_number_i;
    end
    idx_q <= diff[IDX_W-1:0];
  end

  assign diff     = page_q - base_q;
  assign in_range = (page_q >= base_q) && (diff < PAGE_W'(live_cnt));

  // word and bit of a given index
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  q_q;
  logic [IDX_W-1:0]  rem_full;
  logic [BIT_W-1:0]  rem_q;

  assign prod     = PROD_W'(idx_q) * PROD_W'(DIV_MUL);
  assign rem_full = idx_q - q_q * IDX_W'(WORD_BITS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_mul) begin
      q_q <= prod[DIV_SHIFT +: IDX_W];
    end
    if (cmd_i.div_rem) begin
      rem_q <= rem_full[BIT_W-1:0];
    end
  end

  // clearing pass
  logic [ADDR_W-1:0] clr_addr_q;
  logic              clear_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
    end
  end

  assign clear_last = (clr_addr_q == ADDR_W'(MAP_WORDS - 1));

  // scan: request stage and evaluate stage
  logic [FIRST_W-1:0]   req_first_q;
  logic [ADDR_W-1:0]    req_addr_q;
  logic                 eval_vld_q;
  logic [FIRST_W-1:0]   eval_first_q;
  logic [ADDR_W-1:0]    eval_addr_q;
  logic                 req_active;
  logic [FIRST_W-1:0]   span;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] avail;
  logic [BIT_W-1:0]     low_bit;
  logic                 scan_hit;
  logic                 scan_miss;
  logic [WORD_BITS-1:0] rd_data;

  assign req_active = req_first_q < FIRST_W'(live_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_vld_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      eval_vld_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      eval_vld_q <= req_active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      req_first_q <= '0;
      req_addr_q  <= '0;
    end else if (cmd_i.scan_step && req_active) begin
      req_first_q <= req_first_q + FIRST_W'(WORD_BITS);
      req_addr_q  <= req_addr_q + ADDR_W'(1);
    end
    if (cmd_i.scan_step) begin
      eval_first_q <= req_first_q;
      eval_addr_q  <= req_addr_q;
    end
  end

  assign span = FIRST_W'(live_cnt) - eval_first_q;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      valid_mask[b] = FIRST_W'(b) < span;
    end
  end

  assign avail = ~rd_data & valid_mask;

  // lowest free bit
  always_comb begin
    low_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        low_bit = BIT_W'(b);
      end
    end
  end

  assign scan_hit  = eval_vld_q && (avail != '0);
  assign scan_miss = !eval_vld_q && !req_active;

  // bitmap memory
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] scan_bit;
  logic [WORD_BITS-1:0] mod_bit;

  assign scan_bit = {{(WORD_BITS-1){1'b0}}, 1'b1} << low_bit;
  assign mod_bit  = {{(WORD_BITS-1){1'b0}}, 1'b1} << rem_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(q_q);
    ram_wdata = '0;
    if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
    end else if (cmd_i.scan_step) begin
      ram_we    = scan_hit;
      ram_waddr = eval_addr_q;
      ram_wdata = rd_data | scan_bit;
    end else if (cmd_i.modify) begin
      ram_we    = 1'b1;
      ram_wdata = (op_q == OP_MARK) ? (rd_data | mod_bit) : (rd_data & ~mod_bit);
    end
  end

  assign ram_raddr = cmd_i.scan_step ? req_addr_q : ADDR_W'(q_q);

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  // pending result
  status_e          res_status_q;
  logic             res_alloc_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [FIRST_W-1:0] hit_sum;

  assign hit_sum = eval_first_q + FIRST_W'(low_bit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && scan_hit) begin
      res_status_q <= STS_OK;
      res_alloc_q  <= 1'b1;
      hit_idx_q    <= hit_sum[IDX_W-1:0];
    end else if (cmd_i.scan_step && scan_miss) begin
      res_status_q <= STS_NO_FREE;
      res_alloc_q  <= 1'b0;
    end else if (cmd_i.res_we) begin
      res_status_q <= cmd_i.res_status;
      res_alloc_q  <= 1'b0;
    end
  end

  // output register
  logic                out_vld_q;
  logic [PAGE_W-1:0]   out_page_q;
  status_e             out_status_q;
  logic                out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_page_q   <= res_alloc_q ? (base_q + PAGE_W'(hit_idx_q)) : '0;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_page_o = out_page_q;
  assign status_o      = out_status_q;

  assign sts_o.op         = op_q;
  assign sts_o.in_range   = in_range;
  assign sts_o.scan_hit   = scan_hit;
  assign sts_o.scan_miss  = scan_miss;
  assign sts_o.clear_last = clear_last;
  assign sts_o.out_free   = out_free;

endmodule

// ===== hw/rtl/bitmap_page_allocator_core.sv =====
`timescale 1ns / 1ps

// first-fit physical page allocator over a bitmap, one bit per managed page
// input channel: in_valid_i / in_stall_o carry opcode_i and page_number_i;
//   a transfer happens on a clock edge with valid high and stall low
// output channel: out_valid_o / out_stall_i carry result_page_o and status_o,
//   exactly one result per input transfer, in order
// config port: cfg_we_i writes cfg_data_i to base_page (index 0) or
//   page_count (index 1); write only while no operation is in flight
// sequence: an in-range free or mark steps through the check, divide, fetch
//   and modify states, an out-of-range page or a no-op goes from check to
//   done; an allocate scans the words of the window until one has a free page
//   or none has; the result then waits in done until the output is free
// throughput: one operation at a time; the map memory is scanned one word per
//   cycle through its single read port, which sets the allocate time
// reset: the map memory is cleared by a pass over its MAP_WORDS words (1024 by
//   default), one word per cycle, with in_stall_o held high; config writes
//   are taken during the pass
// output stall: the result sits in an output register, so a new input transfer
//   is taken while it waits; the next result is held back until it is taken

module bitmap_page_allocator_core #(
  parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpa_pkg::PAGE_W-1:0]    cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bpa_pkg::OP_W-1:0]      opcode_i,
  input  logic [bpa_pkg::PAGE_W-1:0]    page_number_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpa_pkg::PAGE_W-1:0]    result_page_o,
  output logic [bpa_pkg::STATUS_W-1:0]  status_o
);

  import bpa_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // controller: clear pass, op decode, scan and read-modify-write sequencing
  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: config registers, bitmap memory, scan pipeline, output register
  bpa_dpath #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (opcode_i),
    .page_number_i (page_number_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_page_o (result_page_o),
    .status_o      (status_o)
  );

  // one operation at a time: a transfer closes the input until it is done
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an operation is in flight");

  // nothing is taken in the first cycle after reset, the clear pass runs first
  a_clear_first: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input open before the map clear pass");

  // a nonzero page only comes with an ok status
  a_page_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_page_o != '0) |-> (status_o == STATUS_W'(STS_OK)))
    else $error("page returned with an error status");

  // a failed allocate returns page zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_W'(STS_NO_FREE)) |-> (result_page_o == '0))
    else $error("failed allocate with nonzero page");

endmodule
